### rtl/core/wgtg_pkg.sv
`timescale 1ns / 1ps
// Package for the waypoint go-to-goal controller.
// Holds sizes, fixed-point constants, register indexes and the CORDIC arctangent table.
package wgtg_pkg;

    localparam int WAYPOINT_COUNT    = 4;
    localparam int CORDIC_ITERATIONS = 16;
    localparam int DW                = 38;
    localparam int ZW                = 32;
    localparam int EW                = 34;
    localparam int ITW               = 5;

    localparam logic signed [ZW-1:0] PI_Q28    = 32'sd843314857;
    localparam logic signed [EW-1:0] PI_E      = 34'sd843314857;
    localparam logic signed [EW-1:0] TWO_PI_E  = 34'sd1686629714;
    localparam logic        [16:0]   INV_K_Q16 = 17'd39797;

    typedef enum logic [2:0] {
        REG_WP0    = 3'd0,
        REG_WP1    = 3'd1,
        REG_WP2    = 3'd2,
        REG_WP3    = 3'd3,
        REG_TOL    = 3'd4,
        REG_GAIN   = 3'd5,
        REG_MINSPD = 3'd6,
        REG_MAXSPD = 3'd7
    } reg_idx_t;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_QMUL  = 8'b0000_0010,
        S_CLOAD = 8'b0000_0100,
        S_CITER = 8'b0000_1000,
        S_ERR   = 8'b0001_0000,
        S_RATE  = 8'b0010_0000,
        S_DIST  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    function automatic logic signed [ZW-1:0] atan_q28(input logic [ITW-1:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:    v = 32'sd210828714;
            5'd1:    v = 32'sd124459457;
            5'd2:    v = 32'sd65760959;
            5'd3:    v = 32'sd33381290;
            5'd4:    v = 32'sd16755422;
            5'd5:    v = 32'sd8385879;
            5'd6:    v = 32'sd4193963;
            5'd7:    v = 32'sd2097109;
            5'd8:    v = 32'sd1048571;
            5'd9:    v = 32'sd524287;
            5'd10:   v = 32'sd262144;
            5'd11:   v = 32'sd131072;
            5'd12:   v = 32'sd65536;
            5'd13:   v = 32'sd32768;
            5'd14:   v = 32'sd16384;
            5'd15:   v = 32'sd8192;
            5'd16:   v = 32'sd4096;
            5'd17:   v = 32'sd2048;
            5'd18:   v = 32'sd1024;
            5'd19:   v = 32'sd512;
            5'd20:   v = 32'sd256;
            5'd21:   v = 32'sd128;
            5'd22:   v = 32'sd64;
            5'd23:   v = 32'sd32;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/waypoint_go_to_goal_controller.sv
`timescale 1ns / 1ps
// Top level of the waypoint go-to-goal controller: APB registers, sequencer,
// one shared multiplier and one shared vectoring CORDIC. Depends on wgtg_pkg.
// Sequence: when the waypoint is reached the result goes straight to the output;
// otherwise the four quaternion products, two CORDIC passes of CORDIC_ITERATIONS steps
// plus a load state each, then the error, rate and distance states, on the single CORDIC stage and multiplier.
// A new word is taken only in idle, after the result has been handed off while out_stall is low.
// Reset (rst_n low, asynchronous) restores the register defaults and target 0.
module waypoint_go_to_goal_controller
    import wgtg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [23:0] pos_x,
    input  logic signed [23:0] pos_y,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic signed [15:0] quat_w,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               command_valid,
    output logic [11:0]        linear_speed,
    output logic signed [15:0] angular_rate,
    output logic [1:0]         target_index
);

    logic [47:0] wp_reg [4];
    logic [11:0] tol_reg, minspd_reg, maxspd_reg;
    logic [15:0] gain_reg;
    logic [1:0]  tidx_reg;
    state_t      state_reg;
    logic [1:0]  mcnt_reg;
    logic [ITW-1:0] iter_reg;
    logic        pass_reg;
    logic signed [15:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic signed [24:0] dx_reg, dy_reg;
    logic signed [EW-1:0] ax_reg, ay_reg, err_reg;
    logic signed [DW-1:0] cx_reg, cy_reg, mag_reg;
    logic signed [ZW-1:0] cz_reg, yaw_reg;
    logic        ov_reg, cmd_reg;
    logic [11:0] spd_reg;
    logic signed [15:0] rate_reg;

    logic        cfg_wr;
    reg_idx_t    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[5:3]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        case (cfg_idx)
            REG_WP0:    prdata = {16'd0, wp_reg[0]};
            REG_WP1:    prdata = {16'd0, wp_reg[1]};
            REG_WP2:    prdata = {16'd0, wp_reg[2]};
            REG_WP3:    prdata = {16'd0, wp_reg[3]};
            REG_TOL:    prdata = {52'd0, tol_reg};
            REG_GAIN:   prdata = {48'd0, gain_reg};
            REG_MINSPD: prdata = {52'd0, minspd_reg};
            REG_MAXSPD: prdata = {52'd0, maxspd_reg};
            default:    prdata = 64'd0;
        endcase
    end

    logic [47:0]        wp_sel;
    logic signed [24:0] dx_in, dy_in, adx, ady;
    logic               reached;
    logic [1:0]         tidx_next;
    logic [2:0]         tidx_inc;

    assign wp_sel   = wp_reg[tidx_reg];
    assign dx_in    = 25'(signed'(wp_sel[47:24])) - 25'(pos_x);
    assign dy_in    = 25'(signed'(wp_sel[23:0])) - 25'(pos_y);
    assign adx      = dx_in[24] ? -dx_in : dx_in;
    assign ady      = dy_in[24] ? -dy_in : dy_in;
    assign reached  = (adx < 25'(signed'({1'b0, tol_reg})))
                   && (ady < 25'(signed'({1'b0, tol_reg})));
    assign tidx_inc = {1'b0, tidx_reg} + 3'd1;
    assign tidx_next = (tidx_inc >= 3'(WAYPOINT_COUNT)) ? 2'd0 : tidx_inc[1:0];

    // Shared multiplier.
    logic signed [DW-1:0] mul_a;
    logic signed [16:0]   mul_b;
    logic signed [54:0]   mul_p;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_QMUL:
            begin
                case (mcnt_reg)
                    2'd0:    begin mul_a = DW'(qy_reg); mul_b = 17'(qy_reg); end
                    2'd1:    begin mul_a = DW'(qz_reg); mul_b = 17'(qz_reg); end
                    2'd2:    begin mul_a = DW'(qw_reg); mul_b = 17'(qz_reg); end
                    default: begin mul_a = DW'(qx_reg); mul_b = 17'(qy_reg); end
                endcase
            end
            S_RATE:  begin mul_a = DW'(err_reg); mul_b = signed'({1'b0, gain_reg}); end
            S_DIST:  begin mul_a = mag_reg; mul_b = signed'(INV_K_Q16); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_p = 55'(mul_a) * 55'(mul_b);

    // CORDIC load and step.
    logic signed [DW-1:0] vx, vy, xs, ys, cx_step, cy_step;
    logic signed [ZW-1:0] cz_step;
    logic                 last_iter;

    always_comb
    begin
        if (pass_reg)
        begin
            vx = DW'(dx_reg) <<< 8;
            vy = DW'(dy_reg) <<< 8;
        end
        else
        begin
            vx = (DW'(1) <<< 28) - (DW'(ax_reg) <<< 1);
            vy = DW'(ay_reg) <<< 1;
        end
    end

    assign xs = cx_reg >>> iter_reg;
    assign ys = cy_reg >>> iter_reg;
    assign cx_step = cy_reg[DW-1] ? cx_reg - ys : cx_reg + ys;
    assign cy_step = cy_reg[DW-1] ? cy_reg + xs : cy_reg - xs;
    assign cz_step = cy_reg[DW-1] ? cz_reg - atan_q28(iter_reg) : cz_reg + atan_q28(iter_reg);
    assign last_iter = (iter_reg == ITW'(CORDIC_ITERATIONS - 1));

    // Heading error wrap.
    logic signed [EW-1:0] e0, e1, e2, e3, e4;

    always_comb
    begin
        e0 = EW'(cz_reg) - EW'(yaw_reg);
        e1 = (e0 >= PI_E) ? e0 - TWO_PI_E : e0;
        e2 = (e1 >= PI_E) ? e1 - TWO_PI_E : e1;
        e3 = (e2 < -PI_E) ? e2 + TWO_PI_E : e2;
        e4 = (e3 < -PI_E) ? e3 + TWO_PI_E : e3;
    end

    // Rate and distance from the product.
    logic signed [54:0] rsum, dsum;
    logic signed [26:0] rq;
    logic signed [30:0] dq;
    logic signed [15:0] rate_sat;
    logic [11:0]        spd_hi, spd_fin;

    assign rsum = mul_p + (55'sd1 <<< 27);
    assign rq   = 27'(rsum >>> 28);
    assign rate_sat = (rq > 27'sd32767) ? 16'sh7fff :
                      (rq < -27'sd32768) ? -16'sh8000 : 16'(rq);
    assign dsum = mul_p + (55'sd1 <<< 23);
    assign dq   = 31'(dsum >>> 24);
    assign spd_hi  = (dq > 31'(maxspd_reg)) ? maxspd_reg : dq[11:0];
    assign spd_fin = (spd_hi < minspd_reg) ? minspd_reg : spd_hi;

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg[0]  <= 48'd68719480832;
            wp_reg[1]  <= 48'd274877906944;
            wp_reg[2]  <= 48'd137455726592;
            wp_reg[3]  <= 48'd0;
            tol_reg    <= 12'd41;
            gain_reg   <= 16'd8192;
            minspd_reg <= 12'd819;
            maxspd_reg <= 12'd2048;
            tidx_reg   <= 2'd0;
            state_reg  <= S_IDLE;
            ov_reg     <= 1'b0;
            mcnt_reg   <= 2'd0;
            iter_reg   <= '0;
            pass_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_idx)
                    REG_WP0:    wp_reg[0]  <= pwdata[47:0];
                    REG_WP1:    wp_reg[1]  <= pwdata[47:0];
                    REG_WP2:    wp_reg[2]  <= pwdata[47:0];
                    REG_WP3:    wp_reg[3]  <= pwdata[47:0];
                    REG_TOL:    tol_reg    <= pwdata[11:0];
                    REG_GAIN:   gain_reg   <= pwdata[15:0];
                    REG_MINSPD: minspd_reg <= pwdata[11:0];
                    REG_MAXSPD: maxspd_reg <= pwdata[11:0];
                    default:    ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (reached)
                        begin
                            tidx_reg  <= tidx_next;
                            ov_reg    <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            mcnt_reg  <= 2'd0;
                            state_reg <= S_QMUL;
                        end
                    end
                end
                S_QMUL:
                begin
                    mcnt_reg <= mcnt_reg + 2'd1;
                    if (mcnt_reg == 2'd3)
                    begin
                        pass_reg  <= 1'b0;
                        state_reg <= S_CLOAD;
                    end
                end
                S_CLOAD:
                begin
                    iter_reg <= '0;
                    if (vx == '0 && vy == '0)
                    begin
                        pass_reg  <= 1'b1;
                        state_reg <= pass_reg ? S_ERR : S_CLOAD;
                    end
                    else
                    begin
                        state_reg <= S_CITER;
                    end
                end
                S_CITER:
                begin
                    iter_reg <= iter_reg + ITW'(1);
                    if (last_iter)
                    begin
                        pass_reg  <= 1'b1;
                        state_reg <= pass_reg ? S_ERR : S_CLOAD;
                    end
                end
                S_ERR:   state_reg <= S_RATE;
                S_RATE:  state_reg <= S_DIST;
                S_DIST:
                begin
                    ov_reg    <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        ov_reg    <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                qx_reg   <= quat_x;
                qy_reg   <= quat_y;
                qz_reg   <= quat_z;
                qw_reg   <= quat_w;
                dx_reg   <= dx_in;
                dy_reg   <= dy_in;
                ax_reg   <= '0;
                ay_reg   <= '0;
                cmd_reg  <= 1'b0;
                spd_reg  <= 12'd0;
                rate_reg <= 16'sd0;
            end
            S_QMUL:
            begin
                if (mcnt_reg[1])
                    ay_reg <= ay_reg + EW'(mul_p);
                else
                    ax_reg <= ax_reg + EW'(mul_p);
            end
            S_CLOAD:
            begin
                if (vx == '0 && vy == '0)
                begin
                    cz_reg  <= '0;
                    mag_reg <= '0;
                    if (!pass_reg)
                        yaw_reg <= '0;
                end
                else if (vx[DW-1])
                begin
                    cx_reg <= -vx;
                    cy_reg <= -vy;
                    cz_reg <= vy[DW-1] ? -PI_Q28 : PI_Q28;
                end
                else
                begin
                    cx_reg <= vx;
                    cy_reg <= vy;
                    cz_reg <= '0;
                end
            end
            S_CITER:
            begin
                cx_reg <= cx_step;
                cy_reg <= cy_step;
                cz_reg <= cz_step;
                if (last_iter)
                begin
                    if (pass_reg)
                        mag_reg <= cx_step;
                    else
                        yaw_reg <= cz_step;
                end
            end
            S_ERR:  err_reg <= e4;
            S_RATE: rate_reg <= rate_sat;
            S_DIST:
            begin
                spd_reg <= spd_fin;
                cmd_reg <= 1'b1;
            end
            default: ;
        endcase
    end

    assign out_valid     = ov_reg;
    assign command_valid = cmd_reg;
    assign linear_speed  = spd_reg;
    assign angular_rate  = rate_reg;
    assign target_index  = tidx_reg;

`ifndef ASSERT_OFF
    a_busy_when_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while a result is pending");
    a_zero_when_reached: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !command_valid) |-> (linear_speed == 12'd0 && angular_rate == 16'sd0))
        else $error("nonzero command on a reached waypoint");
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, target_index} < 3'(WAYPOINT_COUNT)))
        else $error("target index out of range");
    a_index_moves_only_on_reach: assert property (@(posedge clk) disable iff (!rst_n)
        (target_index != $past(target_index)) |-> (out_valid && !command_valid))
        else $error("target index changed without reaching a waypoint");
`endif

endmodule
